@@ sv/csx_pkg.sv @@
// Shared types, widths and register indexes for the CAN signal extract and scale block.
// Used by every module of the block; depends on nothing.
package csx_pkg;

  // Field widths.
  localparam int ID_W       = 29;
  localparam int PAYLOAD_W  = 64;
  localparam int START_W    = 6;
  localparam int LEN_W      = 7;
  localparam int FACTOR_W   = 32;
  localparam int OFFSET_W   = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Partial products are 33 x 32 bits; the full product fits in 97 bits signed.
  localparam int PART_W = 65;
  localparam int PROD_W = 97;
  localparam int SUM_W  = 98;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_ID     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_LEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOROLA     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_FIELD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_OFFSET = 3'd6;

  // Reset values of the descriptor.
  localparam logic [LEN_W-1:0]           RESET_FIELD_LEN    = 7'd8;
  localparam logic signed [FACTOR_W-1:0] RESET_SCALE_FACTOR = 32'sd65536;

  // Saturation limits.
  localparam logic signed [63:0] PHYS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] PHYS_MIN = 64'sh8000_0000_0000_0000;

  // Input transaction.
  typedef struct packed {
    logic [ID_W-1:0]      frame_id;
    logic [PAYLOAD_W-1:0] payload;
  } frame_t;

  // Result transaction.
  typedef struct packed {
    logic                 matched;
    logic [63:0]          raw_value;
    logic signed [63:0]   physical_value;
    logic                 saturated;
  } result_t;

  // Signal descriptor.
  typedef struct packed {
    logic [ID_W-1:0]             match_id;
    logic [START_W-1:0]          first_bit;
    logic [LEN_W-1:0]            field_len;
    logic                        motorola;
    logic                        signed_field;
    logic signed [FACTOR_W-1:0]  scale_factor;
    logic signed [OFFSET_W-1:0]  scale_offset;
  } cfg_t;

  // Extracted field handed from the extract stages to the scale stages.
  typedef struct packed {
    logic        valid;
    logic        matched;
    logic [63:0] raw;
    logic        raw_neg;
  } field_t;

  // Reverses the byte order of the payload so Motorola bits run MSB first.
  function automatic logic [PAYLOAD_W-1:0] byte_swap(input logic [PAYLOAD_W-1:0] din);
    logic [PAYLOAD_W-1:0] dout;
    for (int b = 0; b < 8; b++) begin
      dout[8*(7-b) +: 8] = din[8*b +: 8];
    end
    return dout;
  endfunction

endpackage

@@ sv/can_signal_extract_scale_top.sv @@
// Pipeline: a frame accepted at a clock edge passes five register stages, extract stages
// A and B and scale stages C, D and E, before its result is on the ports with done high.
// Throughput: one frame per cycle; busy is low whenever rst is low.
// Reset: synchronous, active high; clears the pipeline valid bits and returns the
// descriptor to its reset values. The receiver cannot stall, so results never wait.
// Depends on csx_pkg, csx_cfg, csx_extract and csx_scale.
module can_signal_extract_scale_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  csx_pkg::frame_t                frame,
  output logic                           done,
  output csx_pkg::result_t               result,
  input  logic                           cfg_we,
  input  logic [csx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csx_pkg::CFG_DATA_W-1:0] cfg_data
);
  import csx_pkg::*;

  cfg_t   cfg;
  field_t fld;
  logic   accept;

  // A transaction is taken in every cycle outside reset in which start is high.
  assign busy   = rst;
  assign accept = start && !busy;

  csx_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  csx_extract u_extract (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .frame    (frame),
    .cfg      (cfg),
    .fld      (fld)
  );

  csx_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .fld    (fld),
    .cfg    (cfg),
    .done   (done),
    .result (result)
  );

endmodule

@@ sv/csx_cfg.sv @@
// Descriptor register file written through the plain configuration port.
// Depends on csx_pkg.
module csx_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [csx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csx_pkg::CFG_DATA_W-1:0] cfg_data,
  output csx_pkg::cfg_t                  cfg
);
  import csx_pkg::*;

  // Each write lands in the register its index names; other indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_id     <= '0;
      cfg.first_bit    <= '0;
      cfg.field_len    <= RESET_FIELD_LEN;
      cfg.motorola     <= 1'b0;
      cfg.signed_field <= 1'b0;
      cfg.scale_factor <= RESET_SCALE_FACTOR;
      cfg.scale_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATCH_ID:     cfg.match_id     <= cfg_data[ID_W-1:0];
        REG_FIRST_BIT:    cfg.first_bit    <= cfg_data[START_W-1:0];
        REG_FIELD_LEN:    cfg.field_len    <= cfg_data[LEN_W-1:0];
        REG_MOTOROLA:     cfg.motorola     <= cfg_data[0];
        REG_SIGNED_FIELD: cfg.signed_field <= cfg_data[0];
        REG_SCALE_FACTOR: cfg.scale_factor <= $signed(cfg_data[FACTOR_W-1:0]);
        REG_SCALE_OFFSET: cfg.scale_offset <= $signed(cfg_data[OFFSET_W-1:0]);
        default: ;
      endcase
    end
  end

endmodule

@@ sv/csx_extract.sv @@
// Two pipeline stages: identifier match and field alignment, then masking and sign extension.
// Depends on csx_pkg.
module csx_extract (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  csx_pkg::frame_t frame,
  input  csx_pkg::cfg_t   cfg,
  output csx_pkg::field_t fld
);
  import csx_pkg::*;

  logic [PAYLOAD_W-1:0]   swapped;
  logic [START_W-1:0]     moto_first;
  logic [7:0]             moto_shift;
  logic [2*PAYLOAD_W-1:0] moto_wide;
  logic [PAYLOAD_W-1:0]   align_next;
  logic                   matched_next;

  logic                   valid_a;
  logic                   matched_a;
  logic [PAYLOAD_W-1:0]   align_a;

  logic                   len_ok;
  logic [PAYLOAD_W-1:0]   mask;
  logic [START_W-1:0]     sign_idx;
  logic [PAYLOAD_W-1:0]   masked;
  logic                   sign_next;
  logic [PAYLOAD_W-1:0]   raw_next;

  // Stage A: Intel fields shift down from the start bit. Motorola fields are read from
  // the byte-swapped payload, where the sawtooth order becomes a plain MSB-first run;
  // bits past the last byte fall into the zero half of the wide word.
  always_comb begin
    swapped      = byte_swap(frame.payload);
    moto_first   = {cfg.first_bit[5:3], ~cfg.first_bit[2:0]};
    moto_shift   = 8'd128 - {2'b00, moto_first} - {1'b0, cfg.field_len};
    moto_wide    = {swapped, {PAYLOAD_W{1'b0}}} >> moto_shift[6:0];
    align_next   = cfg.motorola ? moto_wide[PAYLOAD_W-1:0] : (frame.payload >> cfg.first_bit);
    matched_next = (frame.frame_id == cfg.match_id);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    matched_a <= matched_next;
    align_a   <= align_next;
  end

  // Stage B: low field_len bits, sign-extended if signed; zero for lengths of 0 or over 64.
  always_comb begin
    len_ok    = (cfg.field_len != '0) && (cfg.field_len <= 7'd64);
    mask      = cfg.field_len[6] ? {PAYLOAD_W{1'b1}}
                                 : ~({PAYLOAD_W{1'b1}} << cfg.field_len[5:0]);
    sign_idx  = cfg.field_len[5:0] - 6'd1;
    masked    = align_a & mask;
    sign_next = cfg.signed_field && len_ok && masked[sign_idx];
    if (!len_ok) begin
      raw_next = '0;
    end else if (sign_next) begin
      raw_next = masked | ~mask;
    end else begin
      raw_next = masked;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fld.valid <= 1'b0;
    end else begin
      fld.valid <= valid_a;
    end
    fld.matched <= matched_a;
    fld.raw     <= raw_next;
    fld.raw_neg <= sign_next;
  end

endmodule

@@ sv/csx_scale.sv @@
// Three pipeline stages: split multiply, product merge, offset add with saturation.
// Depends on csx_pkg.
module csx_scale (
  input  logic             clk,
  input  logic             rst,
  input  csx_pkg::field_t  fld,
  input  csx_pkg::cfg_t    cfg,
  output logic             done,
  output csx_pkg::result_t result
);
  import csx_pkg::*;

  logic signed [32:0]       hi_part;
  logic signed [32:0]       lo_part;
  logic signed [PART_W-1:0] prod_hi_next;
  logic signed [PART_W-1:0] prod_lo_next;

  logic                     valid_c;
  logic                     matched_c;
  logic [63:0]              raw_c;
  logic signed [PART_W-1:0] prod_hi_c;
  logic signed [PART_W-1:0] prod_lo_c;

  logic signed [PROD_W-1:0] prod_next;
  logic                     valid_d;
  logic                     matched_d;
  logic [63:0]              raw_d;
  logic signed [PROD_W-1:0] prod_d;

  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-64:0]        sum_top;
  logic                     over;
  result_t                  result_next;

  // Stage C: the raw value, read as 65-bit signed, times the factor in two halves.
  always_comb begin
    hi_part      = $signed({fld.raw_neg, fld.raw[63:32]});
    lo_part      = $signed({1'b0, fld.raw[31:0]});
    prod_hi_next = hi_part * cfg.scale_factor;
    prod_lo_next = lo_part * cfg.scale_factor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_c <= 1'b0;
    end else begin
      valid_c <= fld.valid;
    end
  end

  always_ff @(posedge clk) begin
    matched_c <= fld.matched;
    raw_c     <= fld.raw;
    prod_hi_c <= prod_hi_next;
    prod_lo_c <= prod_lo_next;
  end

  // Stage D: merge the partial products into the exact product.
  always_comb begin
    prod_next = (PROD_W'(prod_hi_c) <<< 32) + PROD_W'(prod_lo_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_d <= 1'b0;
    end else begin
      valid_d <= valid_c;
    end
  end

  always_ff @(posedge clk) begin
    matched_d <= matched_c;
    raw_d     <= raw_c;
    prod_d    <= prod_next;
  end

  // Stage E: add the offset and clip to the 64-bit range; a miss yields all zeros.
  always_comb begin
    sum     = SUM_W'(prod_d) + SUM_W'(cfg.scale_offset);
    sum_top = sum[SUM_W-1:63];
    over    = !((&sum_top) || !(|sum_top));
    result_next.matched        = matched_d;
    result_next.raw_value      = matched_d ? raw_d : '0;
    result_next.saturated      = matched_d && over;
    if (!matched_d) begin
      result_next.physical_value = '0;
    end else if (over) begin
      result_next.physical_value = sum[SUM_W-1] ? PHYS_MIN : PHYS_MAX;
    end else begin
      result_next.physical_value = sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_d;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

@@ sv/csx_checker.sv @@
// Port-level checks on the CAN signal extract and scale block, bound to its top level.
// Depends on csx_pkg and can_signal_extract_scale_top.
module csx_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input csx_pkg::result_t               result
);
  import csx_pkg::*;

  // Every accepted transaction produces its result, with done high.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("accepted frame produced no result on time");

  // A result never appears without a matching accepted transaction.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result without a matching accepted frame");

  // An identifier miss reports all-zero fields.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.matched) |->
      (result.raw_value == '0 && result.physical_value == '0 && !result.saturated))
    else $error("unmatched frame with nonzero result fields");

  // A clipped value sits at one of the two limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (done && result.saturated) |->
      (result.physical_value == PHYS_MAX || result.physical_value == PHYS_MIN))
    else $error("saturated result not at a range limit");

endmodule

bind can_signal_extract_scale_top csx_checker u_csx_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .result    (result)
);

@@ sim/can_signal_extract_scale_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for can_signal_extract_scale_top: drives CAN frames under
// many signal descriptors and checks each result against a built-in decoder.
// Depends on csx_pkg and the can_signal_extract_scale_top RTL.
module can_signal_extract_scale_top_test;
  import csx_pkg::*;

  localparam int NUM_RANDOM_PHASES = 24;
  localparam int FRAMES_PER_PHASE  = 65;
  localparam int DRAIN_CYCLES      = 10;
  localparam int WATCHDOG_LIMIT    = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [ID_W-1:0]      ID_MAX     = 29'h1FFF_FFFF;

  // Percent of cycles the sender holds off, one entry per phase in rotation.
  localparam int IDLE_TABLE [4] = '{0, 85, 0, 31};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  frame_t frame = '0;
  logic done;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frame_t frame_queue [$];
  result_t pending_results [$];
  cfg_t desc;
  result_t want;
  logic hs_taken = 1'b0;
  int idle_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;

  can_signal_extract_scale_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .frame(frame),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Decodes one frame against a descriptor: bit field extraction, sign extension,
  // exact Q.16 scaling and 64-bit saturation.
  function automatic result_t decode_signal(cfg_t d, frame_t f);
    result_t r;
    logic [63:0] raw;
    logic raw_neg;
    int len;
    int cur;
    logic signed [129:0] rv;
    logic signed [129:0] fv;
    logic signed [129:0] ov;
    logic signed [129:0] sum;
    r = '0;
    raw = '0;
    raw_neg = 1'b0;
    if (f.frame_id != d.match_id) begin
      return r;
    end
    len = int'(d.field_len);
    if (len >= 1 && len <= 64) begin
      cur = int'(d.first_bit);
      for (int i = 0; i < len; i++) begin
        if (d.motorola) begin
          // Motorola order: MSB first, down within a byte, then to bit 7 of the next.
          if (cur < 64) raw[len-1-i] = f.payload[cur];
          cur = (cur % 8 == 0) ? cur + 15 : cur - 1;
        end else begin
          if (cur + i < 64) raw[i] = f.payload[cur+i];
        end
      end
      if (d.signed_field && len < 64 && raw[len-1]) begin
        raw = raw | ~((64'd1 << len) - 64'd1);
      end
      raw_neg = d.signed_field && raw[63];
    end
    rv = raw_neg ? {{66{1'b1}}, raw} : {66'b0, raw};
    fv = {{98{d.scale_factor[FACTOR_W-1]}}, d.scale_factor};
    ov = {{82{d.scale_offset[OFFSET_W-1]}}, d.scale_offset};
    sum = rv * fv + ov;
    r.matched = 1'b1;
    r.raw_value = raw;
    if (sum[129:63] == {67{sum[129]}}) begin
      r.physical_value = sum[63:0];
    end else begin
      r.physical_value = sum[129] ? PHYS_MIN : PHYS_MAX;
      r.saturated = 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
    end
  endtask

  // Driver: presents queued frames at the falling edge and holds each until accepted.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || hs_taken) begin
      if (frame_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        frame <= frame_queue.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: mirrors register writes, predicts accepted transactions, checks results.
  always @(posedge clk) begin
    if (rst) begin
      desc = '0;
      desc.field_len = RESET_FIELD_LEN;
      desc.scale_factor = RESET_SCALE_FACTOR;
      hs_taken = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MATCH_ID:     desc.match_id = cfg_data[ID_W-1:0];
          REG_FIRST_BIT:    desc.first_bit = cfg_data[START_W-1:0];
          REG_FIELD_LEN:    desc.field_len = cfg_data[LEN_W-1:0];
          REG_MOTOROLA:     desc.motorola = cfg_data[0];
          REG_SIGNED_FIELD: desc.signed_field = cfg_data[0];
          REG_SCALE_FACTOR: desc.scale_factor = cfg_data[FACTOR_W-1:0];
          REG_SCALE_OFFSET: desc.scale_offset = cfg_data[OFFSET_W-1:0];
          default: ;
        endcase
      end
      if (done) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, result);
        end else begin
          want = pending_results.pop_front();
          check_field("matched", 64'(want.matched), 64'(result.matched));
          check_field("raw_value", want.raw_value, result.raw_value);
          check_field("physical_value", want.physical_value, result.physical_value);
          check_field("saturated", 64'(want.saturated), 64'(result.saturated));
        end
      end
      hs_taken = start && !busy;
      if (hs_taken) begin
        pending_results.insert(pending_results.size(), decode_signal(desc, frame));
      end
    end

    // Watchdog on cycles without any transaction or register write.
    if (hs_taken || done || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Writes one register; bits above the register's width carry random junk.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value, int width);
    logic [63:0] junk;
    logic [63:0] mask;
    junk = {$urandom, $urandom};
    mask = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'((junk & ~mask) | (value & mask));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_desc(logic [ID_W-1:0] id, logic [START_W-1:0] sb, logic [LEN_W-1:0] len,
                          logic be, logic sg, logic [FACTOR_W-1:0] fac,
                          logic [OFFSET_W-1:0] off);
    write_reg(REG_MATCH_ID, 64'(id), ID_W);
    write_reg(REG_FIRST_BIT, 64'(sb), START_W);
    write_reg(REG_FIELD_LEN, 64'(len), LEN_W);
    write_reg(REG_MOTOROLA, 64'(be), 1);
    write_reg(REG_SIGNED_FIELD, 64'(sg), 1);
    write_reg(REG_SCALE_FACTOR, 64'(fac), FACTOR_W);
    write_reg(REG_SCALE_OFFSET, 64'(off), OFFSET_W);
  endtask

  task automatic add_frame(logic [ID_W-1:0] id, logic [PAYLOAD_W-1:0] data);
    frame_t f;
    f.frame_id = id;
    f.payload = data;
    frame_queue.insert(frame_queue.size(), f);
  endtask

  // Waits until every queued frame is sent and every result has come back.
  task automatic wait_idle();
    while (frame_queue.size() != 0 || start || pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Picks a descriptor leaning toward extreme identifiers, lengths, factors and offsets.
  task automatic rand_desc();
    logic [ID_W-1:0] id;
    logic [LEN_W-1:0] len;
    logic [FACTOR_W-1:0] fac;
    logic [63:0] off;
    case ($urandom_range(7))
      0: id = '0;
      1: id = ID_MAX;
      default: id = ID_W'($urandom);
    endcase
    case ($urandom_range(15))
      0: len = 7'd1;
      1: len = 7'd64;
      2: len = $urandom_range(1) ? 7'd0 : 7'($urandom_range(127, 65));
      default: len = 7'($urandom_range(64, 1));
    endcase
    case ($urandom_range(7))
      0: fac = 32'h8000_0000;
      1: fac = 32'h7FFF_FFFF;
      2: fac = 32'($urandom_range(262144)) - 32'd131072;
      default: fac = $urandom;
    endcase
    case ($urandom_range(7))
      0: off = 64'h8000_0000_0000;
      1: off = 64'h7FFF_FFFF_FFFF;
      2: off = '0;
      default: off = {$urandom, $urandom};
    endcase
    set_desc(id, 6'($urandom_range(63)), len, 1'($urandom), 1'($urandom), fac, off[47:0]);
    write_reg(REG_UNUSED, {$urandom, $urandom}, 64);
  endtask

  // Stimulus sequence: directed descriptors first, then random ones.
  initial begin
    logic [ID_W-1:0] id;
    logic [PAYLOAD_W-1:0] data;
    int r;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Reset descriptor: 8-bit Intel field at bit 0, factor 1.0, identifier 0.
    idle_pct = IDLE_TABLE[0];
    add_frame('0, '0);
    add_frame('0, '1);
    add_frame(29'd1, 64'h0123_4567_89AB_CDEF);
    add_frame(ID_MAX, '1);
    wait_idle();

    // Full-width signed Intel field with the most negative factor and largest offset.
    idle_pct = IDLE_TABLE[1];
    set_desc(ID_MAX, 6'd0, 7'd64, 1'b0, 1'b1, 32'h8000_0000, 48'h7FFF_FFFF_FFFF);
    add_frame(ID_MAX, '1);
    add_frame(ID_MAX, 64'h8000_0000_0000_0000);
    add_frame(ID_MAX, 64'h7FFF_FFFF_FFFF_FFFF);
    add_frame('0, '1);
    wait_idle();

    // Full-width unsigned Motorola field, largest factor, most negative offset.
    idle_pct = IDLE_TABLE[2];
    set_desc(29'h123, 6'd7, 7'd64, 1'b1, 1'b0, 32'h7FFF_FFFF, 48'h8000_0000_0000);
    add_frame(29'h123, '1);
    add_frame(29'h123, '0);
    add_frame(29'h123, 64'h0123_4567_89AB_CDEF);
    add_frame(29'h123, {$urandom, $urandom});
    wait_idle();

    // Motorola field that runs past byte 7, signed, factor -1.0 in raw units.
    idle_pct = IDLE_TABLE[3];
    set_desc(29'h0ABC_DEF0, 6'd58, 7'd20, 1'b1, 1'b1, 32'hFFFF_FFFF, 48'd0);
    add_frame(29'h0ABC_DEF0, '1);
    add_frame(29'h0ABC_DEF0, 64'h0400_0000_0000_0000);
    add_frame(29'h0ABC_DEF0, {$urandom, $urandom});
    wait_idle();

    // Intel field that runs past byte 7, signed.
    idle_pct = IDLE_TABLE[0];
    set_desc(29'h7FF, 6'd60, 7'd12, 1'b0, 1'b1, 32'h0001_0000, 48'h0000_0001_0000);
    add_frame(29'h7FF, '1);
    add_frame(29'h7FF, 64'h8000_0000_0000_0000);
    add_frame(29'h7FF, 64'h7000_0000_0000_0000);
    wait_idle();

    // Zero length and over-long fields give the offset alone.
    idle_pct = IDLE_TABLE[1];
    set_desc(29'h55, 6'd3, 7'd0, 1'b0, 1'b1, 32'h8000_0000, 48'hFFFF_FFFF_FFFB);
    add_frame(29'h55, '1);
    add_frame(29'h55, {$urandom, $urandom});
    wait_idle();
    set_desc(29'h55, 6'd63, 7'd100, 1'b1, 1'b1, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF);
    add_frame(29'h55, '1);
    add_frame(29'h55, '0);
    wait_idle();

    // Random descriptors, each followed by a batch of frames mostly aimed at it.
    for (int p = 0; p < NUM_RANDOM_PHASES; p++) begin
      idle_pct = IDLE_TABLE[p % 4];
      rand_desc();
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        r = $urandom_range(99);
        if (r < 75) begin
          id = desc.match_id;
        end else if (r < 85) begin
          id = desc.match_id ^ (29'd1 << $urandom_range(ID_W - 1));
        end else begin
          id = ID_W'($urandom);
        end
        case ($urandom_range(19))
          0: data = '1;
          1: data = '0;
          default: data = {$urandom, $urandom};
        endcase
        add_frame(id, data);
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
